>>> sv/pkr_pkg.sv
// shared types, constants and letter coding for the two-bit nucleotide packer
package pkr_pkg;

  localparam int IdWidth    = 31;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int DivSteps   = IdWidth;
  localparam int DivCountW  = $clog2(DivSteps);

  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_C_UP = 8'h43;
  localparam logic [7:0] CH_G_UP = 8'h47;
  localparam logic [7:0] CH_T_UP = 8'h54;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_C_LO = 8'h63;
  localparam logic [7:0] CH_G_LO = 8'h67;
  localparam logic [7:0] CH_T_LO = 8'h74;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  localparam logic [1:0] KIND_BASES = 2'd0;
  localparam logic [1:0] KIND_TAG   = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic       REG_REDUNDANCY = 1'b0;
  localparam logic [7:0] REDUNDANCY_RST = 8'd1;

  typedef struct packed {
    logic               has_byte;
    logic [7:0]         byte_val;
    logic               is_final;
    logic [IdWidth-1:0] seq_id;
    logic               qry;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTE,
    ST_TRAIL,
    ST_DIV,
    ST_TAG,
    ST_QUERY
  } back_state_t;

  function automatic logic [1:0] code_of(input logic [7:0] ch);
    logic [1:0] c;
    case (ch)
      CH_C_UP, CH_C_LO: c = CODE_C;
      CH_G_UP, CH_G_LO: c = CODE_G;
      CH_T_UP, CH_T_LO: c = CODE_T;
      default:          c = CODE_A;
    endcase
    return c;
  endfunction

endpackage

>>> sv/dna_seed_packer_2bit.sv
// top level: config register, front end, command queue and back end
// letters are taken one beat per cycle while the 4-entry command queue has room
// a packed byte goes via the command queue and back end byte state into the output register
// a sequence end runs trailer, divide, tag and query states if redundancy is above 1
// (else trailer, query); the divide is the bit-serial remainder unit (one id bit per cycle)
// synchronous reset empties the queue and output, clears packing state, redundancy to 1
module dna_seed_packer_2bit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  letter,
  input  logic        carries_letter,
  input  logic        final_letter,
  input  logic [30:0] sequence_id,
  input  logic        query_flag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  byte_kind,
  output logic        end_of_seed
);

  logic [7:0] redundancy;
  logic       reg_hit;
  logic       accept;
  logic       push;
  logic       pop;

  pkr_pkg::cmd_t          front_cmd;
  pkr_pkg::cmd_t          q_cmd;
  pkr_pkg::queue_status_t q_status;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == pkr_pkg::REG_REDUNDANCY);
  assign prdata  = reg_hit ? {24'd0, redundancy} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      redundancy <= pkr_pkg::REDUNDANCY_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      redundancy <= pwdata[7:0];
    end
  end

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  pkr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .letter         (letter),
    .carries_letter (carries_letter),
    .final_letter   (final_letter),
    .sequence_id    (sequence_id),
    .query_flag     (query_flag),
    .push           (push),
    .cmd            (front_cmd)
  );

  pkr_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (front_cmd),
    .pop    (pop),
    .rd_cmd (q_cmd),
    .status (q_status)
  );

  pkr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .redundancy  (redundancy),
    .q_status    (q_status),
    .q_cmd       (q_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_kind   (byte_kind),
    .end_of_seed (end_of_seed)
  );

endmodule

>>> sv/pkr_front.sv
// front end: accepts letters, packs codes and builds byte and trailer commands
module pkr_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [7:0]                 letter,
  input  logic                       carries_letter,
  input  logic                       final_letter,
  input  logic [pkr_pkg::IdWidth-1:0] sequence_id,
  input  logic                       query_flag,
  output logic                       push,
  output pkr_pkg::cmd_t              cmd
);

  logic [1:0] base_count;
  logic [5:0] partial_bits;
  logic [1:0] base_count_next;
  logic [5:0] partial_bits_next;

  logic [1:0] code;
  logic [1:0] cnt_mid;
  logic [5:0] bits_mid;
  logic       full_byte;
  logic [7:0] full_val;
  logic [7:0] flush_val;

  always_comb begin
    code      = pkr_pkg::code_of(letter);
    cnt_mid   = base_count;
    bits_mid  = partial_bits;
    full_byte = 1'b0;
    full_val  = {partial_bits, code};
    if (carries_letter) begin
      if (base_count == 2'd3) begin
        full_byte = 1'b1;
        cnt_mid   = 2'd0;
        bits_mid  = 6'd0;
      end else begin
        cnt_mid  = base_count + 2'd1;
        bits_mid = {partial_bits[3:0], code};
      end
    end
    case (cnt_mid)
      2'd1:    flush_val = {bits_mid[1:0], 6'd0};
      2'd2:    flush_val = {bits_mid[3:0], 4'd0};
      2'd3:    flush_val = {bits_mid, 2'd0};
      default: flush_val = 8'd0;
    endcase

    cmd.has_byte = full_byte || (final_letter && (cnt_mid != 2'd0));
    cmd.byte_val = full_byte ? full_val : flush_val;
    cmd.is_final = final_letter;
    cmd.seq_id   = sequence_id;
    cmd.qry      = query_flag;
    push         = accept && (full_byte || final_letter);

    base_count_next   = final_letter ? 2'd0 : cnt_mid;
    partial_bits_next = final_letter ? 6'd0 : bits_mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_count   <= 2'd0;
      partial_bits <= 6'd0;
    end else if (accept) begin
      base_count   <= base_count_next;
      partial_bits <= partial_bits_next;
    end
  end

endmodule

>>> sv/pkr_queue.sv
// short command queue between the front and back ends
module pkr_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  pkr_pkg::cmd_t          wr_cmd,
  input  logic                   pop,
  output pkr_pkg::cmd_t          rd_cmd,
  output pkr_pkg::queue_status_t status
);

  pkr_pkg::cmd_t mem [pkr_pkg::QueueDepth];

  logic [pkr_pkg::QueuePtrW-1:0] wr_ptr;
  logic [pkr_pkg::QueuePtrW-1:0] rd_ptr;
  logic [pkr_pkg::QueuePtrW:0]   count;

  localparam logic [pkr_pkg::QueuePtrW:0] DepthVal = (pkr_pkg::QueuePtrW+1)'(pkr_pkg::QueueDepth);

  assign rd_cmd       = mem[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == DepthVal);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/pkr_back.sv
// back end: emits packed bytes, computes the tag remainder bit-serially, emits trailer
module pkr_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [7:0]              redundancy,
  input  pkr_pkg::queue_status_t  q_status,
  input  pkr_pkg::cmd_t           q_cmd,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_byte,
  output logic [1:0]              byte_kind,
  output logic                    end_of_seed
);

  pkr_pkg::back_state_t state;
  pkr_pkg::back_state_t state_next;

  pkr_pkg::cmd_t                 cur;
  logic [pkr_pkg::IdWidth-1:0]   dividend;
  logic [pkr_pkg::IdWidth-1:0]   dividend_next;
  logic [7:0]                    rem;
  logic [7:0]                    rem_next;
  logic [pkr_pkg::DivCountW-1:0] step;
  logic [pkr_pkg::DivCountW-1:0] step_next;

  logic       slot_free;
  logic       load;
  logic [7:0] load_byte;
  logic [1:0] load_kind;
  logic       load_last;
  logic [8:0] trial;
  logic [8:0] diff;

  localparam logic [pkr_pkg::DivCountW-1:0] LastStep = pkr_pkg::DivCountW'(pkr_pkg::DivSteps - 1);

  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      pkr_pkg::ST_IDLE: begin
        if (!q_status.empty) begin
          state_next = q_cmd.has_byte ? pkr_pkg::ST_BYTE : pkr_pkg::ST_TRAIL;
        end
      end
      pkr_pkg::ST_BYTE: begin
        if (slot_free) begin
          state_next = cur.is_final ? pkr_pkg::ST_TRAIL : pkr_pkg::ST_IDLE;
        end
      end
      pkr_pkg::ST_TRAIL: begin
        state_next = (redundancy > 8'd1) ? pkr_pkg::ST_DIV : pkr_pkg::ST_QUERY;
      end
      pkr_pkg::ST_DIV: begin
        if (step == LastStep) begin
          state_next = pkr_pkg::ST_TAG;
        end
      end
      pkr_pkg::ST_TAG: begin
        if (slot_free) begin
          state_next = pkr_pkg::ST_QUERY;
        end
      end
      pkr_pkg::ST_QUERY: begin
        if (slot_free) begin
          state_next = pkr_pkg::ST_IDLE;
        end
      end
      default: state_next = pkr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    load          = 1'b0;
    load_byte     = cur.byte_val;
    load_kind     = pkr_pkg::KIND_BASES;
    load_last     = 1'b0;
    dividend_next = dividend;
    rem_next      = rem;
    step_next     = step;
    trial         = {rem, dividend[pkr_pkg::IdWidth-1]};
    diff          = trial - {1'b0, redundancy};
    case (state)
      pkr_pkg::ST_IDLE: begin
        pop = !q_status.empty;
      end
      pkr_pkg::ST_BYTE: begin
        load = slot_free;
      end
      pkr_pkg::ST_TRAIL: begin
        dividend_next = cur.seq_id;
        rem_next      = 8'd0;
        step_next     = '0;
      end
      pkr_pkg::ST_DIV: begin
        dividend_next = {dividend[pkr_pkg::IdWidth-2:0], 1'b0};
        rem_next      = (trial >= {1'b0, redundancy}) ? diff[7:0] : trial[7:0];
        step_next     = step + 1'b1;
      end
      pkr_pkg::ST_TAG: begin
        load      = slot_free;
        load_byte = rem;
        load_kind = pkr_pkg::KIND_TAG;
      end
      pkr_pkg::ST_QUERY: begin
        load      = slot_free;
        load_byte = {7'd0, cur.qry};
        load_kind = pkr_pkg::KIND_QUERY;
        load_last = 1'b1;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pkr_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_cmd;
    end
    if (load) begin
      out_byte    <= load_byte;
      byte_kind   <= load_kind;
      end_of_seed <= load_last;
    end
    dividend <= dividend_next;
    rem      <= rem_next;
    step     <= step_next;
  end

endmodule
